// File: rtl/mrpt_pkg.sv
// ============================================================================
// mrpt_pkg
// Shared widths, command and status types and a modular addition helper for the
// Miller-Rabin prime test core.
// ============================================================================
package mrpt_pkg;

    // Arithmetic width of the candidate inside the core.
    localparam int WIDTH = 32;
    // Width of the candidate and witness fields on the input stream.
    localparam int IN_W = 32;
    // Counter that walks the witness bits during the reduction.
    localparam int DIV_CNT_W = $clog2(IN_W + 1);
    // Counter for the power of two in n-1 (at most WIDTH-1).
    localparam int R_W = $clog2(WIDTH);

    // Operand pair loaded into the modular multiplier.
    typedef enum logic [1:0] {
        MS_ACC_BASE,
        MS_BASE_BASE,
        MS_ACC_ACC
    } t_mul_sel;

    typedef struct packed {
        logic     load;      // latch candidate and witness, start setup
        logic     d_shift;   // strip one factor of two from d
        logic     div_step;  // one bit of the witness reduction
        logic     pow_init;  // acc = 1, base = reduced witness, e = d
        logic     mul_start; // load multiplier operands
        t_mul_sel mul_sel;
        logic     mul_step;  // one shift-and-add step
        logic     wr_acc;    // product to accumulator
        logic     wr_base;   // product to base
        logic     e_shift;   // next exponent bit
        logic     j_inc;     // count one squaring
    } t_dp_cmd;

    typedef struct packed {
        logic n_le1;
        logic n_le3;
        logic n_even;
        logic d_odd;
        logic div_done;
        logic a_trivial;
        logic e_zero;
        logic e_lsb;
        logic mul_done;
        logic x_is1;
        logic x_isnm1;
        logic j_lt_r;
    } t_dp_sts;

    // (x + y) mod m for x, y < m.
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

endpackage

// File: rtl/mrpt_dp.sv
// ============================================================================
// mrpt_dp
// Datapath: candidate decomposition, bit-serial witness reduction and a
// shift-and-add modular multiplier shared by exponentiation and squaring.
// ============================================================================
module mrpt_dp import mrpt_pkg::*; (
    input  logic            i_clk,
    input  logic [IN_W-1:0] i_candidate_number,
    input  logic [IN_W-1:0] i_witness_base,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts
);

    logic [WIDTH-1:0]     r_n, r_nm1, r_d, r_rem, r_acc, r_base, r_e;
    logic [WIDTH-1:0]     r_ma, r_mb, r_mp;
    logic [IN_W-1:0]      r_w;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [R_W-1:0]       r_r, r_j;

    logic [WIDTH:0]       div_t;
    logic [WIDTH:0]       div_r;
    logic [WIDTH-1:0]     n_cand;

    assign n_cand = WIDTH'(i_candidate_number);

    // Restoring reduction step: the partial remainder stays below n.
    always_comb begin
        div_t = {r_rem, r_w[IN_W-1]};
        div_r = (div_t >= {1'b0, r_n}) ? div_t - {1'b0, r_n} : div_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n       <= n_cand;
            r_nm1     <= n_cand - WIDTH'(1);
            r_d       <= n_cand - WIDTH'(1);
            r_r       <= '0;
            r_w       <= i_witness_base;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.d_shift) begin
            r_d <= r_d >> 1;
            r_r <= r_r + R_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_r[WIDTH-1:0];
            r_w       <= r_w << 1;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.pow_init) begin
            r_acc  <= WIDTH'(1);
            r_base <= r_rem;
            r_e    <= r_d;
            r_j    <= R_W'(1);
        end
        if (i_cmd.mul_start) begin
            r_mp <= '0;
            case (i_cmd.mul_sel)
                MS_ACC_BASE: begin
                    r_ma <= r_acc;
                    r_mb <= r_base;
                end
                MS_BASE_BASE: begin
                    r_ma <= r_base;
                    r_mb <= r_base;
                end
                MS_ACC_ACC: begin
                    r_ma <= r_acc;
                    r_mb <= r_acc;
                end
                default: begin
                    r_ma <= r_acc;
                    r_mb <= r_acc;
                end
            endcase
        end
        if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_mp <= add_mod(r_mp, r_ma, r_n);
            end
            r_ma <= add_mod(r_ma, r_ma, r_n);
            r_mb <= r_mb >> 1;
        end
        if (i_cmd.wr_acc) begin
            r_acc <= r_mp;
        end
        if (i_cmd.wr_base) begin
            r_base <= r_mp;
        end
        if (i_cmd.e_shift) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.j_inc) begin
            r_j <= r_j + R_W'(1);
        end
    end

    always_comb begin
        o_sts.n_le1     = (r_n <= WIDTH'(1));
        o_sts.n_le3     = (r_n <= WIDTH'(3));
        o_sts.n_even    = ~r_n[0];
        o_sts.d_odd     = r_d[0];
        o_sts.div_done  = (r_div_cnt == DIV_CNT_W'(IN_W));
        o_sts.a_trivial = (r_rem <= WIDTH'(1)) || (r_rem == r_nm1);
        o_sts.e_zero    = (r_e == '0);
        o_sts.e_lsb     = r_e[0];
        o_sts.mul_done  = (r_mb == '0);
        o_sts.x_is1     = (r_acc == WIDTH'(1));
        o_sts.x_isnm1   = (r_acc == r_nm1);
        o_sts.j_lt_r    = (r_j < r_r);
    end

endmodule

// File: rtl/mrpt_ctrl.sv
// ============================================================================
// mrpt_ctrl
// Sequencer for one witness round, the running pass flag and the verdict
// output register.
// ============================================================================
module mrpt_ctrl import mrpt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_s_tlast,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output logic    o_probably_prime,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_SHIFT,
        S_DIV,
        S_CHKA,
        S_POW,
        S_MUL_A,
        S_MUL_B,
        S_TEST_X,
        S_SQ,
        S_MUL_X,
        S_SQ_CHK,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_item_ok, n_item_ok;
    logic   r_last, r_all_passed, n_all_passed;
    logic   r_m_tvalid, n_m_tvalid;
    logic   r_prime, n_prime;
    logic   s_accept;

    assign o_s_tready       = (r_state == S_IDLE);
    assign s_accept         = i_s_tvalid && o_s_tready;
    assign o_m_tvalid       = r_m_tvalid;
    assign o_probably_prime = r_prime;

    always_comb begin
        n_state      = r_state;
        n_item_ok    = r_item_ok;
        n_all_passed = r_all_passed;
        n_prime      = r_prime;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        o_cmd        = '0;
        o_cmd.mul_sel = MS_ACC_ACC;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.n_le1) begin
                    n_item_ok = 1'b0;
                    n_state   = S_FINISH;
                end else if (i_sts.n_le3) begin
                    n_item_ok = 1'b1;
                    n_state   = S_FINISH;
                end else if (i_sts.n_even) begin
                    n_item_ok = 1'b0;
                    n_state   = S_FINISH;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.d_odd) begin
                    n_state = S_DIV;
                end else begin
                    o_cmd.d_shift = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CHKA;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CHKA: begin
                if (i_sts.a_trivial) begin
                    n_item_ok = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.pow_init = 1'b1;
                    n_state        = S_POW;
                end
            end
            S_POW: begin
                if (i_sts.e_zero) begin
                    n_state = S_TEST_X;
                end else if (i_sts.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_ACC_BASE;
                    n_state         = S_MUL_A;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_BASE_BASE;
                    n_state         = S_MUL_B;
                end
            end
            S_MUL_A: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_acc    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_BASE_BASE;
                    n_state         = S_MUL_B;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_MUL_B: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_base = 1'b1;
                    o_cmd.e_shift = 1'b1;
                    n_state       = S_POW;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_TEST_X: begin
                if (i_sts.x_is1 || i_sts.x_isnm1) begin
                    n_item_ok = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (!i_sts.j_lt_r) begin
                    n_item_ok = 1'b0;
                    n_state   = S_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_ACC_ACC;
                    n_state         = S_MUL_X;
                end
            end
            S_MUL_X: begin
                if (i_sts.mul_done) begin
                    o_cmd.wr_acc = 1'b1;
                    o_cmd.j_inc  = 1'b1;
                    n_state      = S_SQ_CHK;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_SQ_CHK: begin
                if (i_sts.x_isnm1) begin
                    n_item_ok = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_FINISH: begin
                if (!r_last) begin
                    n_all_passed = r_all_passed && r_item_ok;
                    n_state      = S_IDLE;
                end else if (!r_m_tvalid || i_m_tready) begin
                    // The verdict waits here only while an earlier one
                    // is still held in the output register.
                    n_prime      = r_all_passed && r_item_ok;
                    n_m_tvalid   = 1'b1;
                    n_all_passed = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_all_passed <= 1'b1;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_all_passed <= n_all_passed;
            r_m_tvalid   <= n_m_tvalid;
        end
        r_item_ok <= n_item_ok;
        r_prime   <= n_prime;
        if (s_accept) begin
            r_last <= i_s_tlast;
        end
    end

endmodule

// File: rtl/miller_rabin_prime_test_core.sv
// ============================================================================
// miller_rabin_prime_test_core
// Miller-Rabin primality test over runs of witness requests, one verdict per
// run, built as a sequencer driving a bit-serial modular datapath.
// ============================================================================
//
// Channel   Dir  Handshake                 Contents
// s         in   i_s_tvalid / o_s_tready   candidate, witness; tlast = last witness
// m         out  o_m_tvalid / i_m_tready   verdict: probably prime
//
// A request ends early under the small-candidate rules; otherwise the core
// strips the factors of two from n-1, reduces the witness bit by bit, runs
// the exponentiation over the bits of d and then the extra squarings. Every
// modular product runs one bit per cycle through the single shift-and-add
// multiplier.
// Reset is synchronous and active low; it empties the output register and
// sets the running pass flag again. A new request is taken while a verdict
// still waits in the output register; only a second verdict stalls until the
// first one has been taken.
//
module miller_rabin_prime_test_core import mrpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: [31:0] candidate_number, [63:32] witness_base
    input  logic [2*IN_W-1:0]     i_s_tdata,
    input  logic                  i_s_tlast,
    // Master side.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: [0] probably_prime, [7:1] zero
    output logic [7:0]            o_m_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    probably_prime;

    // The sequencer owns the pass flag, the handshakes and the verdict
    // register; the datapath only follows its commands.
    mrpt_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tlast        (i_s_tlast),
        .o_s_tready       (o_s_tready),
        .o_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .o_probably_prime (probably_prime),
        .o_cmd            (cmd),
        .i_sts            (sts)
    );

    // The datapath latches the request fields when the sequencer loads them.
    mrpt_dp u_dp (
        .i_clk              (i_clk),
        .i_candidate_number (i_s_tdata[IN_W-1:0]),
        .i_witness_base     (i_s_tdata[2*IN_W-1:IN_W]),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

    assign o_m_tdata = {7'b0, probably_prime};

    // A request is only taken while the sequencer is idle, so the cycle after
    // an accept must never show ready.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("core ready again right after accepting a request");

    // The multiplier is stepped only while multiplier bits remain.
    a_mul_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul_step |-> !sts.mul_done)
        else $error("multiplier stepped after finishing");

    // The reduction is stepped only while witness bits remain.
    a_div_step_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !sts.div_done)
        else $error("reduction stepped after finishing");

    // Loading the datapath happens exactly on an accepted request.
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load == (i_s_tvalid && o_s_tready))
        else $error("datapath load out of step with the input handshake");

endmodule
